// ----- rtl/fqla_pkg.sv -----
`timescale 1ns / 1ps

package fqla_pkg;

	// Queue geometry (depth must be a power of two so slot indexes wrap)
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths of the channels
	localparam int CMD_W    = 2;
	localparam int REQID_W  = 8;
	localparam int STATUS_W = 2;
	localparam int QCOUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_TRY     = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_OWNER = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/fqla_req_if.sv -----
`timescale 1ns / 1ps

interface fqla_req_if;
	logic                         valid;
	logic                         ready;
	logic [fqla_pkg::CMD_W-1:0]   cmd;
	logic [fqla_pkg::REQID_W-1:0] requester_id;

	modport source (output valid, cmd, requester_id, input ready);
	modport sink (input valid, cmd, requester_id, output ready);
endinterface

// ----- rtl/fqla_rsp_if.sv -----
`timescale 1ns / 1ps

interface fqla_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [fqla_pkg::STATUS_W-1:0] status;
	logic [fqla_pkg::QCOUNT_W-1:0] queue_count;

	modport source (output valid, granted, status, queue_count, input ready);
	modport sink (input valid, granted, status, queue_count, output ready);
endinterface

// ----- rtl/fqla_queue.sv -----
`timescale 1ns / 1ps

// Wait-queue storage: one write port, one registered read port
module fqla_queue (
	input  logic                          clk,
	input  logic                          we,
	input  logic [fqla_pkg::IDX_W-1:0]    waddr,
	input  logic [fqla_pkg::ID_WIDTH-1:0] wdata,
	input  logic [fqla_pkg::IDX_W-1:0]    raddr,
	output logic [fqla_pkg::ID_WIDTH-1:0] rdata
);
	import fqla_pkg::*;

	logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/fifo_queued_lock_arbiter.sv -----
`timescale 1ns / 1ps

// Sequence: accept, then a scan of n queued ids (all for acquire, at most the head
// for the other commands; an empty queue needs no scan), then the result is
// registered in ST_DONE once the response slot is free.
// Throughput: one transaction at a time; the next is accepted once the result is
// registered. The single compare walks the queue one entry per cycle.
// Reset: arst_n clears head, count and handshake state; queue entries are not cleared.
module fifo_queued_lock_arbiter (
	input  logic clk,
	input  logic arst_n,
	fqla_req_if.sink   req,
	fqla_rsp_if.source rsp
);
	import fqla_pkg::*;

	state_t               state_q, state_nx;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     limit_q;
	logic                 pend_q;
	logic                 pend_head_q;
	logic                 found_q;
	logic                 head_hit_q;
	logic                 rsp_valid_q;
	cmd_t                 cmd_q;
	logic [ID_WIDTH-1:0]  id_q;
	logic                 granted_q;
	status_t              status_q;
	logic [CNT_W-1:0]     qcount_q;

	logic                 accept;
	logic                 issue;
	logic                 scan_end;
	logic                 out_free;
	logic                 commit;
	logic                 match;
	logic [IDX_W-1:0]     raddr;
	logic [ID_WIDTH-1:0]  rdata;
	logic                 push;
	logic                 pop;
	logic                 res_granted;
	status_t              res_status;
	logic [CNT_W-1:0]     res_count;
	cmd_t                 in_cmd;

	// Queue memory
	fqla_queue u_queue (
		.clk   (clk),
		.we    (commit && push),
		.waddr (head_q + count_q[IDX_W-1:0]),
		.wdata (id_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_cmd   = cmd_t'(req.cmd);
	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign raddr    = head_q + k_q[IDX_W-1:0];
	assign match    = pend_q && (rdata == id_q);
	assign scan_end = !pend_q && (k_q >= limit_q);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_nx = ST_SCAN;
			ST_SCAN: if (scan_end) state_nx = ST_DONE;
			ST_DONE: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: issue = (k_q < limit_q);
			ST_DONE: commit = out_free;
			default: ;
		endcase
	end

	// Command outcome from the scan flags
	always_comb begin
		push        = 1'b0;
		pop         = 1'b0;
		res_granted = 1'b0;
		res_status  = STS_OK;
		case (cmd_q)
			CMD_ACQUIRE: begin
				if (found_q) begin
					res_granted = head_hit_q;
				end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
					res_status = STS_FULL;
				end else begin
					push        = 1'b1;
					res_granted = (count_q == '0);
				end
			end
			CMD_TRY: begin
				if (count_q == '0) begin
					push        = 1'b1;
					res_granted = 1'b1;
				end else begin
					res_granted = head_hit_q;
				end
			end
			CMD_RELEASE: begin
				if (head_hit_q) begin
					pop = 1'b1;
				end else begin
					res_status = STS_NOT_OWNER;
				end
			end
			CMD_QUERY: res_granted = head_hit_q;
			default: ;
		endcase
		res_count = count_q + CNT_W'(push) - CNT_W'(pop);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			k_q         <= '0;
			limit_q     <= '0;
			pend_q      <= 1'b0;
			pend_head_q <= 1'b0;
			found_q     <= 1'b0;
			head_hit_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				// acquire scans the whole queue, the rest only the head
				k_q        <= '0;
				limit_q    <= (in_cmd == CMD_ACQUIRE) ? count_q :
				              ((count_q != '0) ? CNT_W'(1) : '0);
				found_q    <= 1'b0;
				head_hit_q <= 1'b0;
				pend_q     <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (match) begin
					found_q <= 1'b1;
				end
				if (match && pend_head_q) begin
					head_hit_q <= 1'b1;
				end
				pend_q      <= issue;
				pend_head_q <= issue && (k_q == '0);
				if (issue) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			if (commit) begin
				count_q <= res_count;
				if (pop) begin
					head_q <= head_q + IDX_W'(1);
				end
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			id_q  <= req.requester_id[ID_WIDTH-1:0];
		end
		if (commit) begin
			granted_q <= res_granted;
			status_q  <= res_status;
			qcount_q  <= res_count;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.granted     = granted_q;
	assign rsp.status      = status_q;
	assign rsp.queue_count = QCOUNT_W'(qcount_q);

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && pop) |-> (count_q != '0) && !push)
		else $error("pop from empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(count_q))
		else $error("queue count changed outside commit");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && (k_q == '0))
		else $error("scan did not start after accept");

endmodule
